FILE: rtl/swkr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package swkr_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int OUT_CNT_W   = 5;

   localparam logic [1:0] MODE_PUSH   = 2'd0;
   localparam logic [1:0] MODE_POP    = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_POP_EMPTY = 2'd1;
   localparam logic [1:0] ST_PUSH_FULL = 2'd2;

   typedef enum logic [1:0] {
      OP_NOP    = 2'd0,
      OP_PUSH   = 2'd1,
      OP_POP    = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0]     popped_value;
      logic [1:0]             status;
      logic                   is_empty;
      logic [OUT_CNT_W-1:0]   entry_count;
      logic [OUT_CNT_W-1:0]   removed_count;
   } rsp_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] value;
   } cmd_type;

endpackage
`default_nettype wire

FILE: rtl/stack_with_key_removal_top.sv
// Push, no-op and rejected commands are finished as they are taken; a pop reads its entry and
// answers from S_POP; a remove walks the entries in S_REMOVE and compacts the kept ones.
// No new command is taken while a pop or remove is in flight, nor while the result queue is full.
// 2-deep command and result queues decouple.
// Reset: synchronous, active high; empties both queues and the stack; entry memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module stack_with_key_removal_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire swkr_pkg::req_type req_data,
   output logic                   empty,
   input  wire logic              pop,
   output swkr_pkg::rsp_type      rsp_data
);

   swkr_pkg::cmd_type cmd;
   logic              cmd_valid;
   logic              cmd_take;
   logic              rsp_space;
   logic              rsp_wr;
   swkr_pkg::rsp_type rsp_wdata;

   swkr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take)
   );

   swkr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .rsp_space (rsp_space),
      .rsp_wr    (rsp_wr),
      .rsp_wdata (rsp_wdata)
   );

   swkr_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .wr       (rsp_wr),
      .wdata    (rsp_wdata),
      .space    (rsp_space),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

FILE: rtl/swkr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module swkr_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire swkr_pkg::req_type req_data,
   output swkr_pkg::cmd_type      cmd,
   output logic                   cmd_valid,
   input  wire logic              cmd_take
);

   swkr_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        used_ff, used_in;
   swkr_pkg::cmd_type classified;
   logic              enq, deq;

   always_comb begin
      classified.value = req_data.value;
      case (req_data.mode)
         swkr_pkg::MODE_PUSH:   classified.op = swkr_pkg::OP_PUSH;
         swkr_pkg::MODE_POP:    classified.op = swkr_pkg::OP_POP;
         swkr_pkg::MODE_REMOVE: classified.op = swkr_pkg::OP_REMOVE;
         default:               classified.op = swkr_pkg::OP_NOP;
      endcase
   end

   assign full      = (used_ff == 2'd2);
   assign cmd_valid = (used_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign enq       = push && !full;
   assign deq       = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = enq ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = deq ? !rd_ptr_ff : rd_ptr_ff;
      used_in   = used_ff + {1'b0, enq} - {1'b0, deq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         used_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/swkr_back.sv
`timescale 1ns / 1ps
`default_nettype none
module swkr_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire swkr_pkg::cmd_type cmd,
   input  wire logic              cmd_valid,
   output logic                   cmd_take,
   input  wire logic              rsp_space,
   output logic                   rsp_wr,
   output swkr_pkg::rsp_type      rsp_wdata
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_POP    = 3'b010,
      S_REMOVE = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [swkr_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [swkr_pkg::CNT_W-1:0]    rd_ff, rd_in;
   logic [swkr_pkg::CNT_W-1:0]    wr_ff, wr_in;
   logic [swkr_pkg::CNT_W-1:0]    removed_ff, removed_in;
   logic                          pend_ff, pend_in;
   logic signed [31:0]            key_ff, key_in;

   logic signed [31:0]            entry_store_ff [swkr_pkg::STACK_DEPTH];
   logic signed [31:0]            rd_data_ff;
   logic [swkr_pkg::IDX_W-1:0]    rd_addr;
   logic [swkr_pkg::IDX_W-1:0]    wr_addr;
   logic signed [31:0]            wr_data;
   logic                          wr_en;

   function automatic swkr_pkg::rsp_type make_rsp(
      input logic signed [31:0]         popped,
      input logic [1:0]                 status,
      input logic [swkr_pkg::CNT_W-1:0] count,
      input logic [swkr_pkg::CNT_W-1:0] removed
   );
      swkr_pkg::rsp_type r;
      r.popped_value  = popped;
      r.status        = status;
      r.is_empty      = (count == '0);
      r.entry_count   = swkr_pkg::OUT_CNT_W'(count);
      r.removed_count = swkr_pkg::OUT_CNT_W'(removed);
      return r;
   endfunction

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rd_in      = rd_ff;
      wr_in      = wr_ff;
      removed_in = removed_ff;
      pend_in    = pend_ff;
      key_in     = key_ff;
      cmd_take   = 1'b0;
      rsp_wr     = 1'b0;
      rsp_wdata  = make_rsp('0, swkr_pkg::ST_OK, count_ff, '0);
      rd_addr    = '0;
      wr_addr    = swkr_pkg::IDX_W'(count_ff);
      wr_data    = cmd.value;
      wr_en      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && rsp_space) begin
               cmd_take = 1'b1;
               case (cmd.op)
                  swkr_pkg::OP_PUSH: begin
                     rsp_wr = 1'b1;
                     if (count_ff == swkr_pkg::CNT_W'(swkr_pkg::STACK_DEPTH)) begin
                        rsp_wdata = make_rsp('0, swkr_pkg::ST_PUSH_FULL, count_ff, '0);
                     end else begin
                        wr_en     = 1'b1;
                        count_in  = count_ff + 1'b1;
                        rsp_wdata = make_rsp('0, swkr_pkg::ST_OK, count_in, '0);
                     end
                  end
                  swkr_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        rsp_wr    = 1'b1;
                        rsp_wdata = make_rsp('0, swkr_pkg::ST_POP_EMPTY, count_ff, '0);
                     end else begin
                        count_in = count_ff - 1'b1;
                        rd_addr  = swkr_pkg::IDX_W'(count_in);
                        state_in = S_POP;
                     end
                  end
                  swkr_pkg::OP_REMOVE: begin
                     key_in     = cmd.value;
                     rd_in      = '0;
                     wr_in      = '0;
                     removed_in = '0;
                     pend_in    = 1'b0;
                     state_in   = S_REMOVE;
                  end
                  default: begin
                     rsp_wr = 1'b1;
                  end
               endcase
            end
         end
         S_POP: begin
            rsp_wr    = 1'b1;
            rsp_wdata = make_rsp(rd_data_ff, swkr_pkg::ST_OK, count_ff, '0);
            state_in  = S_IDLE;
         end
         S_REMOVE: begin
            // read of slot rd overlaps compare/write-back of slot rd-1; wr never passes rd
            if (pend_ff) begin
               if (rd_data_ff == key_ff) begin
                  removed_in = removed_ff + 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = swkr_pkg::IDX_W'(wr_ff);
                  wr_data = rd_data_ff;
                  wr_in   = wr_ff + 1'b1;
               end
            end
            if (rd_ff < count_ff) begin
               rd_addr = swkr_pkg::IDX_W'(rd_ff);
               rd_in   = rd_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (!pend_ff && (rd_ff == count_ff)) begin
               count_in  = wr_ff;
               rsp_wr    = 1'b1;
               rsp_wdata = make_rsp('0, swkr_pkg::ST_OK, wr_ff, removed_ff);
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         rd_ff      <= '0;
         wr_ff      <= '0;
         removed_ff <= '0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_ff      <= rd_in;
         wr_ff      <= wr_in;
         removed_ff <= removed_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_store_ff[rd_addr];
   end

endmodule
`default_nettype wire

FILE: rtl/swkr_rsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module swkr_rsp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr,
   input  wire swkr_pkg::rsp_type wdata,
   output logic                   space,
   output logic                   empty,
   input  wire logic              pop,
   output swkr_pkg::rsp_type      rsp_data
);

   swkr_pkg::rsp_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        used_ff, used_in;
   logic              enq, deq;

   assign space    = (used_ff != 2'd2);
   assign empty    = (used_ff == 2'd0);
   assign rsp_data = slot_ff[rd_ptr_ff];
   assign enq      = wr && space;
   assign deq      = pop && !empty;

   always_comb begin
      wr_ptr_in = enq ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = deq ? !rd_ptr_ff : rd_ptr_ff;
      used_in   = used_ff + {1'b0, enq} - {1'b0, deq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         used_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/swkr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module swkr_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              full,
   input wire logic              empty,
   input wire logic              pop,
   input wire swkr_pkg::rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.is_empty == (rsp_data.entry_count == '0)))
      else $error("is_empty disagrees with entry_count");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.status == swkr_pkg::ST_POP_EMPTY) |->
         (rsp_data.popped_value == '0 && rsp_data.is_empty))
      else $error("bad pop-on-empty beat");

   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.status == swkr_pkg::ST_PUSH_FULL) |->
         (rsp_data.entry_count == swkr_pkg::OUT_CNT_W'(swkr_pkg::STACK_DEPTH)))
      else $error("push-full beat without full stack");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("result beat changed while stalled");

endmodule

bind stack_with_key_removal_top swkr_checker u_swkr_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
   import swkr_pkg::*;

   localparam logic [1:0] MODE_NOP = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_CMDS = 1650;
   localparam int HOLD_AFTER = 300;
   localparam int HOLD_CYCLES = 400;
   localparam int CALM_START = 1500;
   localparam int CALM_END = 3000;
   localparam int DRAIN_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full;
   logic empty;
   req_type req_data = '0;
   rsp_type rsp_data;

   req_type pending_cmds[$];
   rsp_type expected_rsps[$];
   logic signed [31:0] shadow_stack [STACK_DEPTH];
   int shadow_fill = 0;

   int cyc = 0;
   int errors = 0;
   int rsp_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   bit req_beat = 1'b0;

   stack_with_key_removal_top u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic rsp_type step_stack(req_type r);
      rsp_type e;
      int keep;
      e = '0;
      case (r.mode)
         MODE_PUSH: begin
            if (shadow_fill >= STACK_DEPTH) begin
               e.status = ST_PUSH_FULL;
            end else begin
               shadow_stack[shadow_fill] = r.value;
               shadow_fill++;
            end
         end
         MODE_POP: begin
            if (shadow_fill == 0) begin
               e.status = ST_POP_EMPTY;
            end else begin
               shadow_fill--;
               e.popped_value = shadow_stack[shadow_fill];
            end
         end
         MODE_REMOVE: begin
            keep = 0;
            for (int i = 0; i < shadow_fill; i++) begin
               if (shadow_stack[i] == r.value) begin
                  e.removed_count = e.removed_count + 5'd1;
               end else begin
                  shadow_stack[keep] = shadow_stack[i];
                  keep++;
               end
            end
            shadow_fill = keep;
         end
         default: ;
      endcase
      e.is_empty = (shadow_fill == 0);
      e.entry_count = 5'(shadow_fill);
      return e;
   endfunction

   function automatic void queue_cmd(logic [1:0] m, logic signed [31:0] v);
      req_type r;
      r.mode = m;
      r.value = v;
      pending_cmds.push_back(r);
   endfunction

   function automatic logic signed [31:0] pick_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) return 32'($signed($urandom_range(7)) - 3);
      if (sel < 90) return $urandom;
      case ($urandom_range(3))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 32'sh0;
         default: return -32'sd1;
      endcase
   endfunction

   function automatic logic [1:0] pick_mode(int bias);
      int sel;
      int push_pct;
      int pop_pct;
      sel = $urandom_range(99);
      case (bias)
         0: begin push_pct = 70; pop_pct = 15; end
         1: begin push_pct = 25; pop_pct = 55; end
         default: begin push_pct = 45; pop_pct = 30; end
      endcase
      if (sel < push_pct) return MODE_PUSH;
      if (sel < push_pct + pop_pct) return MODE_POP;
      if (sel < 95) return MODE_REMOVE;
      return MODE_NOP;
   endfunction

   always @(posedge clock) begin
      cyc <= cyc + 1;
   end

   // monitor: predict on request beats, check on response beats
   always @(posedge clock) begin
      rsp_type want;
      req_beat = !reset && push && !full;
      if (req_beat) begin
         expected_rsps.push_back(step_stack(req_data));
      end
      if (!reset && pop && !empty) begin
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            $error("unexpected response beat");
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.popped_value !== want.popped_value) begin
               $error("popped_value: expected %0d, got %0d",
                      want.popped_value, rsp_data.popped_value);
               errors++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.is_empty !== want.is_empty) begin
               $error("is_empty: expected %0d, got %0d", want.is_empty, rsp_data.is_empty);
               errors++;
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d",
                      want.entry_count, rsp_data.entry_count);
               errors++;
            end
            if (rsp_data.removed_count !== want.removed_count) begin
               $error("removed_count: expected %0d, got %0d",
                      want.removed_count, rsp_data.removed_count);
               errors++;
            end
         end
      end
   end

   // driver
   always @(negedge clock) begin
      bit calm;
      calm = (cyc >= CALM_START) && (cyc < CALM_END);
      if (reset) begin
         push <= 1'b0;
      end else if (!push || req_beat) begin
         if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= 9)) begin
            push <= 1'b1;
            req_data <= pending_cmds.pop_front();
         end else begin
            push <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off to back up the block
   always @(negedge clock) begin
      bit calm;
      calm = (cyc >= CALM_START) && (cyc < CALM_END);
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         pop <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && rsp_count >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         pop <= 1'b0;
      end else begin
         pop <= calm || ($urandom_range(99) >= 9);
      end
   end

   initial begin
      wait (cyc == CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin
      int bias;
      // empty-stack corners and the unused mode, then extreme-value pushes, removes and pops
      queue_cmd(MODE_POP, 32'sh1234_5678);
      queue_cmd(MODE_NOP, 32'sh7fff_ffff);
      queue_cmd(MODE_REMOVE, 32'sh0);
      queue_cmd(MODE_PUSH, 32'sh8000_0000);
      queue_cmd(MODE_PUSH, 32'sh7fff_ffff);
      queue_cmd(MODE_PUSH, -32'sd1);
      queue_cmd(MODE_PUSH, 32'sh8000_0000);
      queue_cmd(MODE_REMOVE, 32'sh8000_0000);
      queue_cmd(MODE_REMOVE, 32'sd42);
      queue_cmd(MODE_POP, 32'sh0);
      queue_cmd(MODE_POP, 32'sh0);
      queue_cmd(MODE_POP, 32'sh0);
      // fill to the top, overflow, then clear with two removes
      for (int i = 0; i < STACK_DEPTH; i++) begin
         queue_cmd(MODE_PUSH, (i % 2 == 0) ? 32'sd5 : -32'sd7);
      end
      queue_cmd(MODE_PUSH, 32'sd9);
      queue_cmd(MODE_REMOVE, 32'sd5);
      queue_cmd(MODE_REMOVE, -32'sd7);
      bias = 2;
      for (int i = 0; i < RANDOM_CMDS; i++) begin
         if (i % 40 == 0) bias = $urandom_range(2);
         queue_cmd(pick_mode(bias), pick_value());
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() > 0 || push || expected_rsps.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/swkr_pkg.sv
rtl/swkr_front.sv
rtl/swkr_back.sv
rtl/swkr_rsp_queue.sv
rtl/stack_with_key_removal_top.sv
rtl/swkr_checker.sv
bench/tb.sv
